// ----- rtl/fpba_pkg.sv -----
`timescale 1ns / 1ps
package fpba_pkg;
    localparam int MaxBlocks = 64;
    localparam int SlotW = 6;
    localparam int LinkW = 7;
    localparam int BaseW = 18;
    localparam int SizeW = 19;
    localparam logic [SizeW-1:0] HeapUnits = 19'd262144;
    localparam logic [LinkW-1:0] NilLink = 7'd64;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic REG_FIT   = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [BaseW-1:0] base;
        logic [SizeW-1:0] size;
        logic             is_free;
        logic [LinkW-1:0] nxt;
        logic [LinkW-1:0] prv;
    } t_blk;
endpackage

// ----- rtl/fit_policy_block_allocator_core.sv -----
`timescale 1ns / 1ps
// block allocator over a 64-entry address-ordered block table held in one
// synchronous memory (one read port, one write port, registered read data).
// start is taken when busy is low; exactly one result follows, flagged by
// o_done for a single cycle, and it cannot be held off. an allocate walks the
// block list one entry at a time (read, then decide), and then runs the pick
// read, the decide, the remainder write, the successor patch and the closing
// state; a zero size or an unused handle goes straight to the closing state.
// busy drops with the strobe, so the next transfer can be taken in that cycle.
// the search walk over the memory port sets an allocate's duration.
// configuration may be written only while idle.
module fit_policy_block_allocator_core
    import fpba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [18:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [20:0] i_req_bytes,
    input  logic [5:0]  i_handle,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [5:0]  o_granted_slot,
    output logic [17:0] o_base_units,
    output logic [18:0] o_block_units,
    output logic        o_was_reuse,
    output logic        o_did_split,
    output logic        o_did_grow,
    output logic [1:0]  o_merges
);
    // states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;  // memory read issued
    localparam logic [3:0] S_WALK   = 4'd2;  // evaluate walked entry
    localparam logic [3:0] S_PICK   = 4'd3;  // read chosen block
    localparam logic [3:0] S_ALLOC  = 4'd4;  // split or grow decision
    localparam logic [3:0] S_FIXN   = 4'd5;  // patch prev of successor
    localparam logic [3:0] S_REL    = 4'd6;  // released block read
    localparam logic [3:0] S_RELN   = 4'd7;  // successor read
    localparam logic [3:0] S_RELA   = 4'd8;  // write surviving block
    localparam logic [3:0] S_RELP   = 4'd9;  // predecessor read
    localparam logic [3:0] S_RELPA  = 4'd10; // prev-link patch of following block
    localparam logic [3:0] S_DONE   = 4'd11;
    localparam logic [3:0] S_FIXN2  = 4'd12; // patch old tail's next link

    // block table memory
    t_blk             mem [MaxBlocks];
    logic             mem_we;
    logic [SlotW-1:0] mem_wa, mem_ra;
    t_blk             mem_wd, mem_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        mem_rd <= mem[mem_ra];
    end

    logic [MaxBlocks-1:0] r_in_use;
    logic [LinkW-1:0] r_head, r_tail, r_cursor, r_p, r_start, r_pick, r_c, r_n, r_prv;
    logic [SizeW-1:0] r_heap_top, r_limit, r_units, r_pick_size;
    logic [1:0]       r_fit, r_merges;
    logic [3:0]       r_state;
    logic [6:0]       r_count;
    t_blk             r_blk;

    // lowest unused slot
    logic [LinkW-1:0] spare;
    always_comb begin
        spare = NilLink;
        for (int i = MaxBlocks - 1; i >= 0; i--)
            if (!r_in_use[i]) spare = LinkW'(i);
    end

    logic [SizeW-1:0] eff_limit;
    assign eff_limit = (r_limit > HeapUnits) ? HeapUnits : r_limit;
    assign busy = (r_state != S_IDLE);

    logic [SizeW:0]   units_full;
    logic [SizeW-1:0] units_in;
    assign units_full = 20'((22'(i_req_bytes) + 22'd3) >> 2);
    // a size past the field can neither fit a block nor grow the heap
    assign units_in = units_full[SizeW] ? '1 : units_full[SizeW-1:0];

    logic fit_ok;
    assign fit_ok = mem_rd.is_free && (mem_rd.size >= r_units);

    // next link for the walk, wrapping for next fit
    logic [LinkW-1:0] walk_nxt;
    always_comb begin
        walk_nxt = mem_rd.nxt;
        if (r_fit == FIT_NEXT && mem_rd.nxt[LinkW-1]) walk_nxt = r_head;
    end

    always_ff @(posedge i_clk) begin
        logic n_mem_we;
        n_mem_we = 1'b0;
        o_done <= i_rst_n && (r_state == S_DONE);
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_in_use <= '0;
            r_head <= NilLink;
            r_tail <= NilLink;
            r_cursor <= NilLink;
            r_heap_top <= '0;
            r_fit <= FIT_FIRST;
            r_limit <= HeapUnits;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FIT) r_fit <= i_cfg_data[1:0];
                else r_limit <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: if (start) begin
                    r_units <= units_in;
                    r_merges <= '0;
                    r_pick <= NilLink;
                    r_count <= '0;
                    o_granted_slot <= '0; o_base_units <= '0;
                    o_block_units <= '0; o_was_reuse <= 1'b0; o_did_split <= 1'b0;
                    o_did_grow <= 1'b0; o_merges <= '0;
                    if (i_kind) begin
                        if (!r_in_use[i_handle]) begin
                            o_status <= ST_INVALID; r_state <= S_DONE;
                        end else begin
                            o_status <= ST_OK;
                            r_c <= {1'b0, i_handle};
                            mem_ra <= i_handle;
                            r_state <= S_REL;
                        end
                    end else if (units_in == '0) begin
                        o_status <= ST_ZERO; r_state <= S_DONE;
                    end else begin
                        logic [LinkW-1:0] st;
                        st = r_head;
                        if (r_fit == FIT_NEXT && !r_cursor[LinkW-1] &&
                            r_in_use[r_cursor[SlotW-1:0]]) st = r_cursor;
                        o_status <= ST_OK;
                        r_start <= st;
                        r_p <= st;
                        if (st[LinkW-1]) r_state <= S_PICK;
                        else begin
                            mem_ra <= st[SlotW-1:0];
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_WALK;
                S_WALK: begin
                    logic done_w;
                    logic [LinkW-1:0] pk;
                    pk = r_pick;
                    done_w = 1'b0;
                    if (fit_ok) begin
                        if (r_fit == FIT_FIRST || r_fit == FIT_NEXT) begin
                            pk = r_p; done_w = 1'b1;
                        end else if (r_pick[LinkW-1] ||
                            (r_fit == FIT_BEST && mem_rd.size < r_pick_size) ||
                            (r_fit == FIT_WORST && mem_rd.size > r_pick_size)) begin
                            pk = r_p;
                            r_pick_size <= mem_rd.size;
                        end
                    end
                    r_pick <= pk;
                    r_count <= r_count + 7'd1;
                    if (walk_nxt[LinkW-1] || (r_fit == FIT_NEXT && walk_nxt == r_start)
                        || r_count == 7'(MaxBlocks - 1))
                        done_w = 1'b1;
                    if (done_w) begin
                        if (r_fit == FIT_NEXT) r_cursor <= pk;
                        if (!pk[LinkW-1]) mem_ra <= pk[SlotW-1:0];
                        r_state <= S_PICK;
                    end else begin
                        r_p <= walk_nxt;
                        mem_ra <= walk_nxt[SlotW-1:0];
                        r_state <= S_RD;
                    end
                end
                S_PICK: begin
                    if (r_fit == FIT_NEXT && r_p[LinkW-1]) r_cursor <= NilLink;
                    r_state <= S_ALLOC;
                end
                S_ALLOC: begin
                    if (!r_pick[LinkW-1]) begin
                        t_blk b;
                        b = mem_rd;
                        b.is_free = 1'b0;
                        o_was_reuse <= 1'b1;
                        o_granted_slot <= r_pick[SlotW-1:0];
                        o_base_units <= b.base;
                        if (b.size > r_units && !spare[LinkW-1]) begin
                            t_blk s;
                            s.base = BaseW'(b.base + BaseW'(r_units));
                            s.size = b.size - r_units;
                            s.is_free = 1'b1;
                            s.prv = r_pick;
                            s.nxt = b.nxt;
                            r_in_use[spare[SlotW-1:0]] <= 1'b1;
                            b.nxt = spare;
                            b.size = r_units;
                            o_did_split <= 1'b1;
                            r_blk <= s;
                            r_n <= spare;
                            if (s.nxt[LinkW-1]) r_tail <= spare;
                            r_state <= S_FIXN;
                        end else r_state <= S_DONE;
                        o_block_units <= b.size;
                        n_mem_we = 1'b1; mem_wa <= r_pick[SlotW-1:0]; mem_wd <= b;
                    end else if (spare[LinkW-1] || r_heap_top > eff_limit ||
                                 r_units > eff_limit - r_heap_top) begin
                        o_status <= ST_NOMEM; r_state <= S_DONE;
                    end else begin
                        t_blk s;
                        s.base = r_heap_top[BaseW-1:0];
                        s.size = r_units; s.is_free = 1'b0;
                        s.nxt = NilLink; s.prv = r_tail;
                        r_in_use[spare[SlotW-1:0]] <= 1'b1;
                        n_mem_we = 1'b1; mem_wa <= spare[SlotW-1:0]; mem_wd <= s;
                        if (r_tail[LinkW-1]) begin
                            r_head <= spare; r_state <= S_DONE;
                        end else begin
                            // tail's next link patched via read-modify-write
                            mem_ra <= r_tail[SlotW-1:0];
                            r_n <= spare; r_c <= r_tail;
                            r_count <= 7'd0;
                            r_state <= S_FIXN2;
                        end
                        r_tail <= spare;
                        r_heap_top <= r_heap_top + r_units;
                        o_did_grow <= 1'b1;
                        o_granted_slot <= spare[SlotW-1:0];
                        o_base_units <= r_heap_top[BaseW-1:0];
                        o_block_units <= r_units;
                    end
                end
                S_FIXN: begin
                    // write split remainder, then patch its successor's prev
                    n_mem_we = 1'b1; mem_wa <= r_n[SlotW-1:0]; mem_wd <= r_blk;
                    if (r_blk.nxt[LinkW-1]) r_state <= S_DONE;
                    else begin
                        mem_ra <= r_blk.nxt[SlotW-1:0];
                        r_c <= r_blk.nxt; r_prv <= r_n;
                        r_state <= S_RELPA;
                        r_count <= 7'd0;
                    end
                end
                S_FIXN2: begin
                    if (r_count == 7'd0) r_count <= 7'd1;
                    else begin
                        t_blk t;
                        t = mem_rd; t.nxt = r_n;
                        n_mem_we = 1'b1; mem_wa <= r_c[SlotW-1:0]; mem_wd <= t;
                        r_state <= S_DONE;
                    end
                end
                S_RELPA: begin
                    // generic prev-link patch: r_c gets prev r_prv
                    if (r_count == 7'd0) r_count <= 7'd1;
                    else begin
                        t_blk t;
                        t = mem_rd; t.prv = r_prv;
                        n_mem_we = 1'b1; mem_wa <= r_c[SlotW-1:0]; mem_wd <= t;
                        r_state <= S_DONE;
                    end
                end
                S_REL: begin
                    if (r_count == 7'd0) r_count <= 7'd1;
                    else if (mem_rd.is_free) begin
                        o_status <= ST_INVALID; r_state <= S_DONE;
                    end else begin
                        t_blk t;
                        t = mem_rd;
                        t.is_free = 1'b1;
                        r_blk <= t;
                        r_count <= 7'd0;
                        if (!mem_rd.nxt[LinkW-1]) begin
                            mem_ra <= mem_rd.nxt[SlotW-1:0];
                            r_state <= S_RELN;
                        end else if (!mem_rd.prv[LinkW-1]) begin
                            mem_ra <= mem_rd.prv[SlotW-1:0];
                            r_state <= S_RELP;
                        end else begin
                            r_state <= S_RELA;
                        end
                    end
                end
                S_RELN: begin
                    if (r_count == 7'd0) r_count <= 7'd1;
                    else begin
                        t_blk t;
                        t = r_blk;
                        r_count <= 7'd0;
                        if (mem_rd.is_free) begin
                            t.size = r_blk.size + mem_rd.size;
                            t.nxt = mem_rd.nxt;
                            r_in_use[r_blk.nxt[SlotW-1:0]] <= 1'b0;
                            if (r_cursor == r_blk.nxt) r_cursor <= r_c;
                            r_merges <= 2'd1;
                            if (mem_rd.nxt[LinkW-1]) r_tail <= r_c;
                        end
                        r_blk <= t;
                        if (!r_blk.prv[LinkW-1]) begin
                            mem_ra <= r_blk.prv[SlotW-1:0];
                            r_state <= S_RELP;
                        end else begin
                            r_state <= S_RELA;
                        end
                    end
                end
                S_RELP: begin
                    if (r_count == 7'd0) r_count <= 7'd1;
                    else begin
                        r_count <= 7'd3;
                        if (mem_rd.is_free) begin
                            t_blk q;
                            q = mem_rd;
                            q.size = mem_rd.size + r_blk.size;
                            q.nxt = r_blk.nxt;
                            r_in_use[r_c[SlotW-1:0]] <= 1'b0;
                            if (r_cursor == r_c ||
                                (r_merges != 2'd0 && r_cursor == r_c)) r_cursor <= r_blk.prv;
                            r_prv <= r_blk.prv;
                            r_c <= r_blk.prv;
                            r_blk <= q;
                            r_merges <= r_merges + 2'd1;
                            if (r_blk.nxt[LinkW-1]) r_tail <= r_blk.prv;
                        end
                        r_state <= S_RELA;
                    end
                end
                S_RELA: begin
                    // write surviving block, then fix successor's prev if a merge moved it
                    n_mem_we = 1'b1; mem_wa <= r_c[SlotW-1:0]; mem_wd <= r_blk;
                    o_granted_slot <= r_c[SlotW-1:0];
                    o_base_units <= r_blk.base;
                    o_block_units <= r_blk.size;
                    o_merges <= r_merges;
                    if (r_merges != 2'd0 && !r_blk.nxt[LinkW-1]) begin
                        mem_ra <= r_blk.nxt[SlotW-1:0];
                        r_prv <= r_c; r_c <= r_blk.nxt;
                        r_count <= 7'd0;
                        r_state <= S_RELPA;
                    end else r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        mem_we <= n_mem_we;
    end

    // a result is only flagged on the way back to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("result outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head[LinkW-1] |-> r_tail[LinkW-1] || busy) else $error("list ends disagree");
endmodule
